// ===== rtl/triangle_unit_normal_top_assert.svh =====
// Assertion macros for the triangle unit normal block
`ifndef TRIANGLE_UNIT_NORMAL_TOP_ASSERT_SVH
`define TRIANGLE_UNIT_NORMAL_TOP_ASSERT_SVH

// Clocked check, idle during reset
`define TUN_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("tun assertion failed");

// Clocked check, also active during reset
`define TUN_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) (prop)) \
    else $error("tun assertion failed");

`endif

// ===== rtl/tun_pkg.sv =====
// Shared constants and types of the triangle unit normal block
package tun_pkg;
  localparam int COORD_BITS_DEF  = 32;
  localparam int NORMAL_BITS_DEF = 16;
  localparam int M_W    = 30;
  localparam int SUM_W  = 2 * M_W + 2;
  localparam int ROOT_W = M_W + 1;
  localparam int REM_W  = ROOT_W + 2;
  localparam int DEN_W  = ROOT_W + 1;

  typedef struct packed {
    logic       vld;
    logic       deg;
    logic [2:0] neg;
  } ctl_t;
endpackage

// ===== rtl/tun_front.sv =====
// Edge vectors, cross product, scaling and sum of squares
module tun_front #(
  parameter int CW = 32
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         en_i,
  input  logic                                         vld_i,
  input  logic [CW-1:0]                                ax_i,
  input  logic [CW-1:0]                                ay_i,
  input  logic [CW-1:0]                                az_i,
  input  logic [CW-1:0]                                bx_i,
  input  logic [CW-1:0]                                by_i,
  input  logic [CW-1:0]                                bz_i,
  input  logic [CW-1:0]                                cx_i,
  input  logic [CW-1:0]                                cy_i,
  input  logic [CW-1:0]                                cz_i,
  output tun_pkg::ctl_t                                ctl_o,
  output logic [2:0][tun_pkg::M_W-1:0]                 m_o,
  output logic [tun_pkg::SUM_W-1:0]                    sum_o
);
  import tun_pkg::*;

  localparam int EW = CW + 1;
  localparam int PW = 2 * EW;
  localparam int NW = PW + 1;
  localparam int MW = 2 * CW + 1;
  localparam int LW = $clog2(MW + 1);
  localparam int SW = MW + M_W;
  localparam int QW = 2 * M_W;

  logic [7:0]                  vld_q;
  logic signed [EW-1:0]        u_q [3];
  logic signed [EW-1:0]        w_q [3];
  logic signed [PW-1:0]        p_q [6];
  logic signed [NW-1:0]        n_q [3];
  logic [MW-1:0]               mag4_q [3];
  logic [2:0]                  neg4_q, neg5_q, neg6_q, neg7_q, neg8_q;
  logic [MW-1:0]               mag5_q [3];
  logic [LW-1:0]               bl_q, bl_d;
  logic [MW-1:0]               any_mag;
  logic [2:0][M_W-1:0]         m6_q, m7_q, m8_q;
  logic                        deg6_q, deg7_q, deg8_q;
  logic [QW-1:0]               sq_q [3];
  logic [SUM_W-1:0]            sum_q;
  logic [SW-1:0]               shf [3];

  always_comb begin
    any_mag = mag4_q[0] | mag4_q[1] | mag4_q[2];
    bl_d = '0;
    for (int i = 0; i < MW; i++) begin
      if (any_mag[i]) bl_d = LW'(i + 1);
    end
    for (int j = 0; j < 3; j++) begin
      shf[j] = {mag5_q[j], {M_W{1'b0}}} >> bl_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[6:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      u_q[0] <= $signed({ax_i[CW-1], ax_i}) - $signed({bx_i[CW-1], bx_i});
      u_q[1] <= $signed({ay_i[CW-1], ay_i}) - $signed({by_i[CW-1], by_i});
      u_q[2] <= $signed({az_i[CW-1], az_i}) - $signed({bz_i[CW-1], bz_i});
      w_q[0] <= $signed({bx_i[CW-1], bx_i}) - $signed({cx_i[CW-1], cx_i});
      w_q[1] <= $signed({by_i[CW-1], by_i}) - $signed({cy_i[CW-1], cy_i});
      w_q[2] <= $signed({bz_i[CW-1], bz_i}) - $signed({cz_i[CW-1], cz_i});
      p_q[0] <= u_q[1] * w_q[2];
      p_q[1] <= u_q[2] * w_q[1];
      p_q[2] <= u_q[2] * w_q[0];
      p_q[3] <= u_q[0] * w_q[2];
      p_q[4] <= u_q[0] * w_q[1];
      p_q[5] <= u_q[1] * w_q[0];
      for (int j = 0; j < 3; j++) begin
        n_q[j]    <= NW'(p_q[2*j]) - NW'(p_q[2*j+1]);
        neg4_q[j] <= n_q[j][NW-1];
        mag4_q[j] <= n_q[j][NW-1] ? MW'(-n_q[j]) : MW'(n_q[j]);
        mag5_q[j] <= mag4_q[j];
        m6_q[j]   <= shf[j][M_W-1:0];
        sq_q[j]   <= QW'(m6_q[j]) * QW'(m6_q[j]);
      end
      bl_q   <= bl_d;
      neg5_q <= neg4_q;
      neg6_q <= neg5_q;
      neg7_q <= neg6_q;
      neg8_q <= neg7_q;
      deg6_q <= (bl_q == '0);
      deg7_q <= deg6_q;
      deg8_q <= deg7_q;
      m7_q   <= m6_q;
      m8_q   <= m7_q;
      sum_q  <= SUM_W'(sq_q[0]) + SUM_W'(sq_q[1]) + SUM_W'(sq_q[2]);
    end
  end

  assign ctl_o = '{vld: vld_q[7], deg: deg8_q, neg: neg8_q};
  assign m_o   = m8_q;
  assign sum_o = sum_q;
endmodule

// ===== rtl/tun_sqrt_cell.sv =====
// One bit of the pipelined integer square root
module tun_sqrt_cell #(
  parameter int STEP = 0
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  tun_pkg::ctl_t                   ctl_i,
  input  logic [tun_pkg::SUM_W-1:0]       sum_i,
  input  logic [tun_pkg::REM_W-1:0]       rem_i,
  input  logic [tun_pkg::ROOT_W-1:0]      root_i,
  input  logic [2:0][tun_pkg::M_W-1:0]    m_i,
  output tun_pkg::ctl_t                   ctl_o,
  output logic [tun_pkg::SUM_W-1:0]       sum_o,
  output logic [tun_pkg::REM_W-1:0]       rem_o,
  output logic [tun_pkg::ROOT_W-1:0]      root_o,
  output logic [2:0][tun_pkg::M_W-1:0]    m_o
);
  import tun_pkg::*;

  logic [REM_W+1:0] acc, trial, diff;
  logic             ge;

  always_comb begin
    acc   = {rem_i, sum_i[SUM_W-1-2*STEP -: 2]};
    trial = {2'b00, root_i, 2'b01};
    diff  = acc - trial;
    ge    = (acc >= trial);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_o <= '0;
    end else if (en_i) begin
      ctl_o <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_o  <= sum_i;
      m_o    <= m_i;
      rem_o  <= ge ? diff[REM_W-1:0] : acc[REM_W-1:0];
      root_o <= {root_i[ROOT_W-2:0], ge};
    end
  end
endmodule

// ===== rtl/tun_div_cell.sv =====
// One quotient bit of the three-lane restoring divider
module tun_div_cell #(
  parameter int FRAC = 14,
  parameter int STEP = 0
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      en_i,
  input  tun_pkg::ctl_t                             ctl_i,
  input  logic [2:0][tun_pkg::M_W+FRAC+1:0]         num_i,
  input  logic [tun_pkg::DEN_W-1:0]                 den_i,
  input  logic [2:0][tun_pkg::REM_W-1:0]            rem_i,
  input  logic [2:0][FRAC:0]                        quo_i,
  output tun_pkg::ctl_t                             ctl_o,
  output logic [2:0][tun_pkg::M_W+FRAC+1:0]         num_o,
  output logic [tun_pkg::DEN_W-1:0]                 den_o,
  output logic [2:0][tun_pkg::REM_W-1:0]            rem_o,
  output logic [2:0][FRAC:0]                        quo_o
);
  import tun_pkg::*;

  logic [2:0][REM_W-1:0] acc, rem_d;
  logic [2:0]            ge;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      acc[j]   = {rem_i[j][REM_W-2:0], num_i[j][FRAC-STEP]};
      ge[j]    = (acc[j] >= {1'b0, den_i});
      rem_d[j] = ge[j] ? acc[j] - {1'b0, den_i} : acc[j];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_o <= '0;
    end else if (en_i) begin
      ctl_o <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_o <= num_i;
      den_o <= den_i;
      rem_o <= rem_d;
      for (int j = 0; j < 3; j++) begin
        quo_o[j] <= {quo_i[j][FRAC-1:0], ge[j]};
      end
    end
  end
endmodule

// ===== rtl/triangle_unit_normal_top.sv =====
// Top level of the triangle unit normal block
// Takes one triangle per cycle and returns its unit face normal in Q1.14 via
// 8 front stages (edges, cross product, scaling and squares), 31 square-root
// cells, one divider setup stage, NORMAL_BITS-1 divider cells and the output
// register. The square root and divide run as chains of one-bit cells, so a
// new triangle is taken every cycle unless the output register is full and
// not being read.
module triangle_unit_normal_top #(
  parameter int COORD_BITS  = tun_pkg::COORD_BITS_DEF,
  parameter int NORMAL_BITS = tun_pkg::NORMAL_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [COORD_BITS-1:0]  ax_i,
  input  logic [COORD_BITS-1:0]  ay_i,
  input  logic [COORD_BITS-1:0]  az_i,
  input  logic [COORD_BITS-1:0]  bx_i,
  input  logic [COORD_BITS-1:0]  by_i,
  input  logic [COORD_BITS-1:0]  bz_i,
  input  logic [COORD_BITS-1:0]  cx_i,
  input  logic [COORD_BITS-1:0]  cy_i,
  input  logic [COORD_BITS-1:0]  cz_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [NORMAL_BITS-1:0] unit_x_o,
  output logic [NORMAL_BITS-1:0] unit_y_o,
  output logic [NORMAL_BITS-1:0] unit_z_o,
  output logic                   degenerate_o
);
  import tun_pkg::*;

  localparam int FRAC = NORMAL_BITS - 2;
  localparam int QW   = FRAC + 1;
  localparam int NUMW = M_W + FRAC + 2;
  localparam int ONE  = 2 ** FRAC;

  logic en;

  ctl_t                  sq_ctl  [ROOT_W+1];
  logic [SUM_W-1:0]      sq_sum  [ROOT_W+1];
  logic [REM_W-1:0]      sq_rem  [ROOT_W+1];
  logic [ROOT_W-1:0]     sq_root [ROOT_W+1];
  logic [2:0][M_W-1:0]   sq_m    [ROOT_W+1];

  ctl_t                  dv_ctl  [QW+1];
  logic [2:0][NUMW-1:0]  dv_num  [QW+1];
  logic [DEN_W-1:0]      dv_den  [QW+1];
  logic [2:0][REM_W-1:0] dv_rem  [QW+1];
  logic [2:0][QW-1:0]    dv_quo  [QW+1];

  ctl_t                  prep_ctl_q;
  logic [2:0][NUMW-1:0]  prep_num_q;
  logic [DEN_W-1:0]      prep_den_q;

  logic [NORMAL_BITS-1:0] res_d [3];
  logic [QW-1:0]          qc;

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  tun_front #(.CW(COORD_BITS)) u_front (
    .clk_i, .rst_ni, .en_i(en), .vld_i(in_valid_i),
    .ax_i, .ay_i, .az_i, .bx_i, .by_i, .bz_i, .cx_i, .cy_i, .cz_i,
    .ctl_o(sq_ctl[0]), .m_o(sq_m[0]), .sum_o(sq_sum[0])
  );
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    tun_sqrt_cell #(.STEP(k)) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .ctl_i(sq_ctl[k]), .sum_i(sq_sum[k]), .rem_i(sq_rem[k]),
      .root_i(sq_root[k]), .m_i(sq_m[k]),
      .ctl_o(sq_ctl[k+1]), .sum_o(sq_sum[k+1]), .rem_o(sq_rem[k+1]),
      .root_o(sq_root[k+1]), .m_o(sq_m[k+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_ctl_q <= '0;
    end else if (en) begin
      prep_ctl_q <= sq_ctl[ROOT_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prep_den_q <= {sq_root[ROOT_W], 1'b0};
      for (int j = 0; j < 3; j++) begin
        prep_num_q[j] <= {1'b0, sq_m[ROOT_W][j], {QW{1'b0}}} + NUMW'(sq_root[ROOT_W]);
      end
    end
  end

  assign dv_ctl[0] = prep_ctl_q;
  assign dv_num[0] = prep_num_q;
  assign dv_den[0] = prep_den_q;
  assign dv_quo[0] = '0;
  for (genvar j = 0; j < 3; j++) begin : g_rem0
    assign dv_rem[0][j] = REM_W'(prep_num_q[j][NUMW-1:QW]);
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    tun_div_cell #(.FRAC(FRAC), .STEP(k)) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .ctl_i(dv_ctl[k]), .num_i(dv_num[k]), .den_i(dv_den[k]),
      .rem_i(dv_rem[k]), .quo_i(dv_quo[k]),
      .ctl_o(dv_ctl[k+1]), .num_o(dv_num[k+1]), .den_o(dv_den[k+1]),
      .rem_o(dv_rem[k+1]), .quo_o(dv_quo[k+1])
    );
  end

  always_comb begin
    qc = '0;
    for (int j = 0; j < 3; j++) begin
      qc = (dv_quo[QW][j] > QW'(ONE)) ? QW'(ONE) : dv_quo[QW][j];
      if (dv_ctl[QW].deg) begin
        res_d[j] = '0;
      end else if (dv_ctl[QW].neg[j]) begin
        res_d[j] = -NORMAL_BITS'(qc);
      end else begin
        res_d[j] = NORMAL_BITS'(qc);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (en) begin
      out_valid_o <= dv_ctl[QW].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      unit_x_o     <= res_d[0];
      unit_y_o     <= res_d[1];
      unit_z_o     <= res_d[2];
      degenerate_o <= dv_ctl[QW].deg;
    end
  end

`include "triangle_unit_normal_top_assert.svh"

  `TUN_ASSERT(a_deg_zero, out_valid_o && degenerate_o |-> unit_x_o == '0 && unit_y_o == '0 && unit_z_o == '0)
  `TUN_ASSERT(a_range, out_valid_o && !degenerate_o |-> $signed(unit_x_o) <= ONE && $signed(unit_x_o) >= -ONE && $signed(unit_y_o) <= ONE && $signed(unit_y_o) >= -ONE && $signed(unit_z_o) <= ONE && $signed(unit_z_o) >= -ONE)
  `TUN_ASSERT(a_nonzero, out_valid_o && !degenerate_o |-> (unit_x_o | unit_y_o | unit_z_o) != '0)
endmodule

// ===== tb/sv/tb_triangle_unit_normal_top.sv =====
// Testbench for triangle_unit_normal_top: predicted unit normals checked per transfer
module tb_triangle_unit_normal_top;
  localparam int CW = tun_pkg::COORD_BITS_DEF;
  localparam int NW = tun_pkg::NORMAL_BITS_DEF;
  localparam int FRAC = NW - 2;

  typedef struct packed {
    logic [NW-1:0] ux;
    logic [NW-1:0] uy;
    logic [NW-1:0] uz;
    logic          deg;
  } normal_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [CW-1:0] ax_i = '0, ay_i = '0, az_i = '0;
  logic [CW-1:0] bx_i = '0, by_i = '0, bz_i = '0;
  logic [CW-1:0] cx_i = '0, cy_i = '0, cz_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [NW-1:0] unit_x_o, unit_y_o, unit_z_o;
  logic degenerate_o;

  normal_t expected_normals[$];
  int mismatches = 0;
  int results_seen = 0;
  int triangles_sent = 0;
  int hold_cycles = 0;
  bit rx_random = 1'b1;

  triangle_unit_normal_top u_top (.*);

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [63:0] isqrt(logic [63:0] v);
    logic [63:0] res, bit_w;
    res = '0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v = v - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return res;
  endfunction

  function automatic normal_t predict_normal(logic [CW-1:0] c[9]);
    logic signed [CW:0] u[3], w[3];
    logic signed [2*CW+3:0] n[3];
    logic [2*CW+3:0] mag[3], any_bits;
    logic [63:0] m[3], sum, len, q;
    int bl;
    normal_t r;
    for (int i = 0; i < 3; i++) begin
      u[i] = $signed(c[i]) - $signed(c[i+3]);
      w[i] = $signed(c[i+3]) - $signed(c[i+6]);
    end
    n[0] = u[1] * w[2] - u[2] * w[1];
    n[1] = u[2] * w[0] - u[0] * w[2];
    n[2] = u[0] * w[1] - u[1] * w[0];
    any_bits = '0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = n[i] < 0 ? -n[i] : n[i];
      any_bits = any_bits | mag[i];
    end
    r = '0;
    if (any_bits == 0) begin
      r.deg = 1'b1;
      return r;
    end
    bl = 0;
    for (int i = 0; i < 2*CW+4; i++) if (any_bits[i]) bl = i + 1;
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      m[i] = bl > 30 ? 64'(mag[i] >> (bl - 30)) : 64'(mag[i] << (30 - bl));
      sum = sum + m[i] * m[i];
    end
    len = isqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << (FRAC + 1)) + len) / (2 * len);
      if (q > (64'd1 << FRAC)) q = 64'd1 << FRAC;
      if (n[i] < 0) q = -q;
      if (i == 0) r.ux = q[NW-1:0];
      else if (i == 1) r.uy = q[NW-1:0];
      else r.uz = q[NW-1:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [NW-1:0] got, logic [NW-1:0] want);
    $display("ERROR result %0d %s: got %h want %h", results_seen, what, got, want);
    mismatches++;
  endtask

  task automatic send_triangle(logic [CW-1:0] c[9], int gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    {ax_i, ay_i, az_i} <= {c[0], c[1], c[2]};
    {bx_i, by_i, bz_i} <= {c[3], c[4], c[5]};
    {cx_i, cy_i, cz_i} <= {c[6], c[7], c[8]};
    expected_normals.push_back(predict_normal(c));
    do @(posedge clk_i); while (!in_ready_o);
    triangles_sent++;
  endtask

  // receiver
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        normal_t e;
        if (expected_normals.size() == 0) begin
          report_mismatch("unexpected transfer", unit_x_o, '0);
        end else begin
          e = expected_normals.pop_front();
          if (unit_x_o !== e.ux) report_mismatch("unit_x", unit_x_o, e.ux);
          if (unit_y_o !== e.uy) report_mismatch("unit_y", unit_y_o, e.uy);
          if (unit_z_o !== e.uz) report_mismatch("unit_z", unit_z_o, e.uz);
          if (degenerate_o !== e.deg) begin
            report_mismatch("degenerate", NW'(degenerate_o), NW'(e.deg));
          end
        end
        results_seen++;
        stall = rx_random ? $urandom_range(0, 6) : 0;
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready_i <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  function automatic logic [CW-1:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return CW'($signed($urandom_range(0, 2000)) - 1000);
      2: return CW'($signed($urandom_range(0, 32'h3ffff)) - 32'h1ffff);
      default: return $urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7fff_ffff;
    endcase
  endfunction

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_normals.size() != 0) @(posedge clk_i);
    repeat (70) @(posedge clk_i);
  endtask

  task automatic test_directed();
    logic [CW-1:0] c[9];
    c = '{default: '0};
    send_triangle(c, 0);
    c = '{32'h10000, 0, 0, 0, 0, 0, 0, 32'h10000, 0};
    send_triangle(c, 0);
    c = '{0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000, 0};
    send_triangle(c, 1);
    c = '{0, 0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000};
    send_triangle(c, 0);
    c = '{1, 2, 3, 2, 4, 6, 3, 6, 9};
    send_triangle(c, 0);
    c = '{32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
          32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000};
    send_triangle(c, 2);
    c = '{32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000000,
          32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000};
    send_triangle(c, 0);
    c = '{32'hffffffff, 0, 0, 0, 32'hffffffff, 0, 0, 0, 32'hffffffff};
    send_triangle(c, 0);
    c = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
    send_triangle(c, 0);
    c = '{32'hffffffff, 32'hffffffff, 32'hffffffff, 0, 0, 0, 1, 0, 0};
    send_triangle(c, 3);
    c = '{default: 32'h7fffffff};
    send_triangle(c, 0);
    c = '{default: 32'hffffffff};
    c[0] = 32'h0;
    send_triangle(c, 0);
    c = '{32'h12345678, 32'h9abcdef0, 32'h0f0f0f0f, 32'hf0f0f0f0, 32'h55555555,
          32'haaaaaaaa, 32'h33333333, 32'hcccccccc, 32'h01010101};
    send_triangle(c, 0);
  endtask

  task automatic test_random(int count);
    logic [CW-1:0] c[9];
    int mode;
    for (int k = 0; k < count; k++) begin
      mode = $urandom_range(0, 3);
      for (int i = 0; i < 9; i++) c[i] = rand_coord($urandom_range(0, 4) == 0 ? 3 : mode);
      if ($urandom_range(0, 19) == 0) begin
        c[6] = c[3] + (c[3] - c[0]);
        c[7] = c[4] + (c[4] - c[1]);
        c[8] = c[5] + (c[5] - c[2]);
      end
      send_triangle(c, (k % 200) < 40 ? 0 : $urandom_range(0, 6));
    end
  endtask

  task automatic test_backpressure();
    logic [CW-1:0] c[9];
    hold_cycles = 150;
    for (int k = 0; k < 80; k++) begin
      for (int i = 0; i < 9; i++) c[i] = rand_coord(0);
      send_triangle(c, 0);
    end
    wait_drained();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    wait_drained();
    test_random(600);
    test_backpressure();
    rx_random = 1'b0;
    test_random(200);
    rx_random = 1'b1;
    test_random(300);
    wait_drained();
    $display("Sent %0d triangles, checked %0d normals incl. degenerate, extremes, stalls",
             triangles_sent, results_seen);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timeout");
    $display("Mismatches found");
    $finish;
  end
endmodule
